// ===== hdl/tsc_pkg.sv =====
// shared types, constants and helpers for the taylor sine/cosine/tangent core
package tsc_pkg;

  // working format: signed Q.32 held in 48 bits
  localparam int WW     = 48;
  localparam int HALF_W = WW / 2;
  localparam int PROD_W = 2 * WW;
  // dividend width of the shared divider (tangent numerator needs the most)
  localparam int DVD_W  = 80;
  localparam int STEP_W = 7;
  // series counters, sized for the largest term limit
  localparam int I_W    = 8;
  localparam int CNT_W  = 7;
  localparam int DEN_W  = 15;
  // configuration port
  localparam int REG_W   = 25;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_STOP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ZERO  = 8'd1;

  localparam logic [STEP_W-1:0] DIV_TERM_STEPS = STEP_W'(WW);
  localparam logic [STEP_W-1:0] DIV_TAN_STEPS  = STEP_W'(DVD_W);

  // 2*pi in Q.32, rounded from pi in Q.62
  localparam logic [63:0] TWO_PI_Q32_64 =
    (64'hC90F_DAA2_2168_C235 + 64'h0000_0000_1000_0000) >> 29;
  localparam logic signed [WW-1:0] TWO_PI_Q32 = TWO_PI_Q32_64[WW-1:0];
  localparam logic signed [WW-1:0] NEG_TWO_PI_Q32 = -TWO_PI_Q32;
  localparam logic signed [WW-1:0] ONE_Q32 = {{(WW-33){1'b0}}, 1'b1, 32'b0};

  typedef enum logic [1:0] {
    CMD_SIN  = 2'd0,
    CMD_COS  = 2'd1,
    CMD_TAN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_REDUCE,
    OP_MUL_SQ,
    OP_SET_X2,
    OP_INIT_SIN,
    OP_INIT_COS,
    OP_SIN_STEP,
    OP_MUL_TERM,
    OP_DIV_TERM,
    OP_SET_TERM,
    OP_COS_SET,
    OP_SAVE_SIN,
    OP_DIV_TAN,
    OP_OUT_SC,
    OP_OUT_TAN,
    OP_OUT_UNDEF,
    OP_OUT_ZERO
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [DEN_W-1:0]  den;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic term_big;
    logic cos_small;
    logic mul_busy;
    logic div_busy;
  } dp_stat_t;

  // magnitude of a signed working value
  function automatic logic [WW-1:0] mag(input logic [WW-1:0] v);
    mag = v[WW-1] ? (~v + {{(WW-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

// ===== hdl/taylor_sine_cosine_tangent_core.sv =====
// top level of the taylor series sine, cosine and tangent core
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  in       | in_valid_i / in_ready_o  | cmd_i, angle_i
//  out      | out_valid_o / out_ready_i| value_o, undefined_o, saturated_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one request at a time; sine or cosine runs the angle reduction steps and then the series
//   terms, tangent runs the sine series, then the cosine series and then one final divide;
//   each term costs a shared multiply and a divide
// the shared radix-2 divider serves both the series terms and the tangent quotient
// reset clears the controller and sets the thresholds to 0 and 1
// a new request is taken while the previous result still waits on out
// configuration is always accepted, writes beyond index 1 are dropped
module taylor_sine_cosine_tangent_core #(
  parameter int MAX_TERMS = 40,
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cmd_i,
  input  logic [31:0]                    angle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    value_o,
  output logic                           undefined_o,
  output logic                           saturated_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsc_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import tsc_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  cmd_e     cmd_in;

  assign cmd_in      = cmd_e'(cmd_i);
  assign cfg_ready_o = 1'b1;

  tsc_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .stat_i      (dp_stat)
  );

  tsc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .angle_i     (angle_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_o     (value_o),
    .undefined_o (undefined_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== hdl/tsc_mul.sv =====
// sequential magnitude multiplier, four 24x24 partial products, Q.32 rounding
module tsc_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [tsc_pkg::WW-1:0]  a_i,
  input  logic [tsc_pkg::WW-1:0]  b_i,
  output logic                    busy_o,
  output logic [tsc_pkg::WW-1:0]  prod_o
);
  import tsc_pkg::*;

  logic [WW-1:0]       a_q, b_q;
  logic [PROD_W-1:0]   acc_q, acc_rnd;
  logic [1:0]          step_q;
  logic                busy_q;
  logic [HALF_W-1:0]   a_half, b_half;
  logic [WW-1:0]       pp;
  logic [PROD_W-1:0]   pp_sh;

  // pick halves for the current partial product
  always_comb begin
    a_half = step_q[1] ? a_q[WW-1:HALF_W] : a_q[HALF_W-1:0];
    b_half = step_q[0] ? b_q[WW-1:HALF_W] : b_q[HALF_W-1:0];
    pp     = WW'(a_half * b_half);
    case (step_q)
      2'd0:    pp_sh = {{WW{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {WW{1'b0}}};
      default: pp_sh = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
    endcase
  end

  // accumulate one partial product per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  // round to nearest at the Q.32 point
  assign acc_rnd = acc_q + PROD_W'(32'h8000_0000);
  assign prod_o  = acc_rnd[32 +: WW];
  assign busy_o  = busy_q;

endmodule

// ===== hdl/tsc_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module tsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsc_pkg::DVD_W-1:0]   dvd_i,
  input  logic [tsc_pkg::WW-1:0]      dsr_i,
  input  logic [tsc_pkg::STEP_W-1:0]  steps_i,
  output logic                        busy_o,
  output logic [tsc_pkg::DVD_W-1:0]   quo_o
);
  import tsc_pkg::*;

  logic [WW-1:0]     rem_q, dsr_q;
  logic [DVD_W-1:0]  dvd_q, quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic [WW:0]       trial, diff;
  logic              ge;

  // trial subtract
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - {{(STEP_W-1){1'b0}}, 1'b1};
      if (cnt_q == {{(STEP_W-1){1'b0}}, 1'b1}) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= dsr_i;
      dvd_q <= dvd_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[WW-1:0] : trial[WW-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/tsc_dp.sv =====
// datapath: angle reduction, series terms, tangent quotient and result register
module tsc_dp #(
  parameter int FRAC_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsc_pkg::dp_cmd_t               cmd_i,
  output tsc_pkg::dp_stat_t              stat_o,
  input  logic [31:0]                    angle_i,
  input  logic                           cfg_valid_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsc_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  output logic [31:0]                    value_o,
  output logic                           undefined_o,
  output logic                           saturated_o
);
  import tsc_pkg::*;

  localparam int SH = 32 - FRAC_BITS;
  localparam logic signed [WW-1:0] RND = WW'(1) << (SH - 1);

  logic [REG_W-1:0]        term_stop_q, cos_zero_q;
  logic signed [WW-1:0]    x_q, term_q, sum_q, sin_q;
  logic [WW-1:0]           x2_q;
  logic                    neg_q;
  logic [31:0]             value_q;
  logic                    undef_q, sat_q;

  logic signed [WW-1:0]    angle_ext, q_s, new_term, sc_rnd;
  logic [WW-1:0]           x_mag, term_mag, cos_mag;
  logic                    mul_start, mul_busy, div_start, div_busy;
  logic [WW-1:0]           mul_a, mul_b, mul_prod, div_dsr;
  logic [DVD_W-1:0]        div_dvd, div_quo, tan_num;
  logic [STEP_W-1:0]       div_steps;
  logic                    tan_neg, tan_pos_ovf, tan_neg_ovf;
  logic [31:0]             tan_val;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_stop_q <= '0;
      cos_zero_q  <= REG_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TERM_STOP) begin
        term_stop_q <= cfg_data_i[REG_W-1:0];
      end else if (cfg_index_i == REG_COS_ZERO) begin
        cos_zero_q <= cfg_data_i[REG_W-1:0];
      end
    end
  end

  // magnitudes, comparisons and status
  always_comb begin
    angle_ext = {{(WW-32){angle_i[31]}}, angle_i};
    x_mag     = mag(x_q);
    term_mag  = mag(term_q);
    cos_mag   = mag(sum_q);
    stat_o.red_done  = !(x_q > TWO_PI_Q32) && !(x_q < NEG_TWO_PI_Q32);
    stat_o.term_big  = term_mag > (WW'(term_stop_q) << SH);
    stat_o.cos_small = (sum_q == '0) || (cos_mag < (WW'(cos_zero_q) << SH));
    stat_o.mul_busy  = mul_busy;
    stat_o.div_busy  = div_busy;
  end

  // unit operand selection
  always_comb begin
    mul_start = (cmd_i.op == OP_MUL_SQ) || (cmd_i.op == OP_MUL_TERM) ||
                (cmd_i.op == OP_SIN_STEP);
    mul_a     = (cmd_i.op == OP_MUL_SQ) ? x_mag : term_mag;
    mul_b     = (cmd_i.op == OP_MUL_SQ) ? x_mag : x2_q;
    tan_num   = (DVD_W'(mag(sin_q)) << FRAC_BITS) + DVD_W'(cos_mag >> 1);
    div_start = (cmd_i.op == OP_DIV_TERM) || (cmd_i.op == OP_DIV_TAN);
    if (cmd_i.op == OP_DIV_TERM) begin
      div_dvd   = {mul_prod, {(DVD_W-WW){1'b0}}};
      div_dsr   = WW'(cmd_i.den);
      div_steps = DIV_TERM_STEPS;
    end else begin
      div_dvd   = tan_num;
      div_dsr   = cos_mag;
      div_steps = DIV_TAN_STEPS;
    end
  end

  // next term, narrowed result and tangent saturation
  always_comb begin
    q_s         = $signed(div_quo[WW-1:0]);
    new_term    = neg_q ? q_s : -q_s;
    sc_rnd      = (sum_q + RND) >>> SH;
    tan_neg     = sin_q[WW-1] ^ sum_q[WW-1];
    tan_pos_ovf = div_quo > DVD_W'(32'h7FFF_FFFF);
    tan_neg_ovf = div_quo > DVD_W'(32'h8000_0000);
    tan_val     = tan_neg ? (~div_quo[31:0] + 32'd1) : div_quo[31:0];
  end

  tsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  tsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dsr_i   (div_dsr),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // working registers and result
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD:     x_q <= angle_ext <<< SH;
      OP_REDUCE: begin
        if (x_q > TWO_PI_Q32) begin
          x_q <= x_q - TWO_PI_Q32;
        end else if (x_q < NEG_TWO_PI_Q32) begin
          x_q <= x_q + TWO_PI_Q32;
        end
      end
      OP_SET_X2:   x2_q <= mul_prod;
      OP_INIT_SIN: begin
        term_q <= x_q;
        sum_q  <= '0;
      end
      OP_INIT_COS: begin
        term_q <= ONE_Q32;
        sum_q  <= ONE_Q32;
      end
      OP_SIN_STEP: begin
        sum_q <= sum_q + term_q;
        neg_q <= term_q[WW-1];
      end
      OP_MUL_TERM: neg_q <= term_q[WW-1];
      OP_SET_TERM: term_q <= new_term;
      OP_COS_SET: begin
        term_q <= new_term;
        sum_q  <= sum_q + new_term;
      end
      OP_SAVE_SIN: sin_q <= sum_q;
      OP_OUT_SC: begin
        value_q <= sc_rnd[31:0];
        undef_q <= 1'b0;
        sat_q   <= 1'b0;
      end
      OP_OUT_TAN: begin
        undef_q <= 1'b0;
        if (!tan_neg && tan_pos_ovf) begin
          value_q <= 32'h7FFF_FFFF;
          sat_q   <= 1'b1;
        end else if (tan_neg && tan_neg_ovf) begin
          value_q <= 32'h8000_0000;
          sat_q   <= 1'b1;
        end else begin
          value_q <= tan_val;
          sat_q   <= 1'b0;
        end
      end
      OP_OUT_UNDEF: begin
        value_q <= '0;
        undef_q <= 1'b1;
        sat_q   <= 1'b0;
      end
      OP_OUT_ZERO: begin
        value_q <= '0;
        undef_q <= 1'b0;
        sat_q   <= 1'b0;
      end
      default: ;
    endcase
  end

  assign value_o     = value_q;
  assign undefined_o = undef_q;
  assign saturated_o = sat_q;

endmodule

// ===== hdl/tsc_ctrl.sv =====
// controller: sequences reduction, series loops, tangent division and output
module tsc_ctrl #(
  parameter int MAX_TERMS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsc_pkg::cmd_e      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsc_pkg::dp_cmd_t   dp_cmd_o,
  input  tsc_pkg::dp_stat_t  stat_i
);
  import tsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED,
    S_SQ_WAIT,
    S_INIT,
    S_CHECK,
    S_MUL_WAIT,
    S_DIV_WAIT,
    S_TAN_CHK,
    S_TAN_WAIT,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic              is_cos_q, is_cos_d;
  logic              undef_q, undef_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [I_W-1:0]    i_q, i_d;
  logic [2*I_W-1:0]  den_full;
  logic              go;
  dp_op_e            op;

  assign den_full = i_q * (i_q - {{(I_W-1){1'b0}}, 1'b1});
  assign go       = stat_i.term_big && (used_q < CNT_W'(MAX_TERMS));

  // next state and datapath command
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    is_cos_d    = is_cos_q;
    undef_d     = undef_q;
    used_d      = used_q;
    i_d         = i_q;
    op          = OP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          cmd_d   = cmd_i;
          undef_d = 1'b0;
          state_d = (cmd_i == CMD_NONE) ? S_OUT : S_RED;
        end
      end
      S_RED: begin
        if (stat_i.red_done) begin
          op      = OP_MUL_SQ;
          state_d = S_SQ_WAIT;
        end else begin
          op = OP_REDUCE;
        end
      end
      S_SQ_WAIT: begin
        if (!stat_i.mul_busy) begin
          op       = OP_SET_X2;
          is_cos_d = (cmd_q == CMD_COS);
          state_d  = S_INIT;
        end
      end
      S_INIT: begin
        op      = is_cos_q ? OP_INIT_COS : OP_INIT_SIN;
        used_d  = is_cos_q ? CNT_W'(1) : '0;
        i_d     = is_cos_q ? I_W'(2) : I_W'(1);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (go) begin
          state_d = S_MUL_WAIT;
          if (is_cos_q) begin
            op = OP_MUL_TERM;
          end else begin
            op     = OP_SIN_STEP;
            used_d = used_q + CNT_W'(1);
            i_d    = i_q + I_W'(2);
          end
        end else if (!is_cos_q && cmd_q == CMD_TAN) begin
          op       = OP_SAVE_SIN;
          is_cos_d = 1'b1;
          state_d  = S_INIT;
        end else if (cmd_q == CMD_TAN) begin
          state_d = S_TAN_CHK;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MUL_WAIT: begin
        if (!stat_i.mul_busy) begin
          op      = OP_DIV_TERM;
          state_d = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = S_CHECK;
          if (is_cos_q) begin
            op     = OP_COS_SET;
            used_d = used_q + CNT_W'(1);
            i_d    = i_q + I_W'(2);
          end else begin
            op = OP_SET_TERM;
          end
        end
      end
      S_TAN_CHK: begin
        if (stat_i.cos_small) begin
          undef_d = 1'b1;
          state_d = S_OUT;
        end else begin
          op      = OP_DIV_TAN;
          state_d = S_TAN_WAIT;
        end
      end
      S_TAN_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          unique case (cmd_q) inside
            CMD_SIN, CMD_COS: op = OP_OUT_SC;
            CMD_TAN:          op = undef_q ? OP_OUT_UNDEF : OP_OUT_TAN;
            default:          op = OP_OUT_ZERO;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_SIN;
      is_cos_q    <= 1'b0;
      undef_q     <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      is_cos_q    <= is_cos_d;
      undef_q     <= undef_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      i_q         <= i_d;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign dp_cmd_o.op  = op;
  assign dp_cmd_o.den = den_full[DEN_W-1:0];

  // no unit is running while a new request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!stat_i.mul_busy && !stat_i.div_busy))
    else $error("arithmetic unit busy in idle");

  // term count never passes the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_TERMS))
    else $error("term count beyond limit");

  // result register is only loaded when free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

  // sine runs odd indexes, cosine even ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (i_q[0] == !is_cos_q))
    else $error("series index parity wrong");

endmodule

// ===== tb/tb_taylor_sine_cosine_tangent_core.sv =====
// testbench for the taylor series sine, cosine and tangent core
module tb_taylor_sine_cosine_tangent_core;
  import tsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PI_HALF_Q24    = 26353589;
  localparam int PI_Q24         = 52707179;
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] BIAS   = 64'h4000_0000_0000_0000;
  localparam int TERMS_LIMIT    = 40;

  typedef struct packed {
    logic [31:0] value;
    logic        undefined;
    logic        saturated;
  } trig_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           cmd_i = '0;
  logic [31:0]          angle_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [31:0]          value_o;
  logic                 undefined_o;
  logic                 saturated_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  // predictor copy of the threshold registers
  logic [63:0]  stop_thr = 64'd0;
  logic [63:0]  zero_thr = 64'd1;
  trig_result_t pending_q[$];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  bit           no_idle = 1'b0;

  taylor_sine_cosine_tangent_core uut (.*);

  // clock
  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // q.32 product, rounded to nearest
  function automatic longint mul_q32(input longint a, input longint b);
    logic [63:0] ua, ub, a0, a1, b0, b1, r;
    ua = mag64(a);
    ub = mag64(b);
    a0 = ua & 64'hFFFF_FFFF;
    a1 = ua >> 32;
    b0 = ub & 64'hFFFF_FFFF;
    b1 = ub >> 32;
    r = ((a1 * b1) << 32) + a0 * b1 + a1 * b0 + ((a0 * b0 + 64'h8000_0000) >> 32);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint sine_sum(input longint x, input logic [63:0] thr);
    longint x2, term, sum, i;
    int used;
    x2 = mul_q32(x, x);
    term = x;
    sum = 0;
    i = 1;
    used = 0;
    while (mag64(term) > thr && used < TERMS_LIMIT) begin
      sum += term;
      used++;
      i += 2;
      term = -(mul_q32(term, x2) / (i * (i - 1)));
    end
    return sum;
  endfunction

  function automatic longint cosine_sum(input longint x, input logic [63:0] thr);
    longint x2, term, sum, i;
    int used;
    x2 = mul_q32(x, x);
    term = longint'(1) << 32;
    sum = term;
    i = 2;
    used = 1;
    while (mag64(term) > thr && used < TERMS_LIMIT) begin
      term = -(mul_q32(term, x2) / (i * (i - 1)));
      sum += term;
      used++;
      i += 2;
    end
    return sum;
  endfunction

  // q.32 to q.24, round half up
  function automatic logic [31:0] to_q24(input longint v);
    logic [63:0] u;
    u = 64'(v) + BIAS + 64'd128;
    return 32'(longint'(u >> 8) - longint'(BIAS >> 8));
  endfunction

  function automatic trig_result_t predict_trig(input logic [1:0] cmd,
                                                input logic [31:0] angle);
    trig_result_t res;
    longint tp, x, s, c;
    logic [63:0] thr, cm, num, q;
    bit neg;
    res = '0;
    tp = longint'((PI_Q62 + 64'h1000_0000) >> 29);
    x = longint'($signed(angle)) * 256;
    while (x > tp) x -= tp;
    while (x < -tp) x += tp;
    thr = stop_thr << 8;
    case (cmd)
      CMD_SIN: res.value = to_q24(sine_sum(x, thr));
      CMD_COS: res.value = to_q24(cosine_sum(x, thr));
      CMD_TAN: begin
        s = sine_sum(x, thr);
        c = cosine_sum(x, thr);
        cm = mag64(c);
        if (c == 0 || cm < (zero_thr << 8)) begin
          res.undefined = 1'b1;
        end else begin
          num = mag64(s) << 24;
          q = (num + cm / 2) / cm;
          neg = (s < 0) != (c < 0);
          if (!neg && q > 64'h7FFF_FFFF) begin
            res.value = 32'h7FFF_FFFF;
            res.saturated = 1'b1;
          end else if (neg && q > 64'h8000_0000) begin
            res.value = 32'h8000_0000;
            res.saturated = 1'b1;
          end else begin
            res.value = neg ? 32'(-longint'(q)) : 32'(q);
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    trig_result_t exp_res;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result value %h", value_o);
        fail_count++;
      end else begin
        exp_res = pending_q.pop_front();
        if (value_o !== exp_res.value) begin
          $error("value expected %h actual %h", exp_res.value, value_o);
          fail_count++;
        end
        if (undefined_o !== exp_res.undefined) begin
          $error("undefined expected %b actual %b", exp_res.undefined, undefined_o);
          fail_count++;
        end
        if (saturated_o !== exp_res.saturated) begin
          $error("saturated expected %b actual %b", exp_res.saturated, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on the in, out or cfg channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_ready_i <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // send one request, holding valid until accepted
  task automatic send_req(input logic [1:0] cmd, input logic [31:0] angle);
    trig_result_t exp_res;
    exp_res = predict_trig(cmd, angle);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    angle_i <= angle;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(exp_res);
  endtask

  // wait until every expected result has come and the core is idle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // register write, only issued while idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_TERM_STOP) stop_thr = 64'(data) & 64'h1FF_FFFF;
    else if (idx == REG_COS_ZERO) zero_thr = 64'(data) & 64'h1FF_FFFF;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 105414357)) - 105414357);
      2: return 32'(($urandom_range(0, 1) ? PI_HALF_Q24 : -PI_HALF_Q24) +
                    ($signed($urandom_range(0, 8)) - 4) * PI_Q24 +
                    $signed($urandom_range(0, 400000)) - 200000);
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // extremes of the angle and every command, at reset thresholds
  task automatic test_directed();
    logic [31:0] angles[8];
    angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'(PI_HALF_Q24),
               32'(-PI_HALF_Q24), 32'(PI_Q24), 32'h1, 32'hFFFF_FFFF};
    foreach (angles[k]) begin
      send_req(CMD_SIN, angles[k]);
      send_req(CMD_COS, angles[k]);
      send_req(CMD_TAN, angles[k]);
    end
    send_req(CMD_NONE, 32'h1234_5678);
    send_req(CMD_NONE, 32'h8000_0000);
  endtask

  // threshold extremes, masking of wide data and dropped indexes
  task automatic test_config();
    cfg_write(REG_TERM_STOP, 32'h0100_0000);
    cfg_write(REG_COS_ZERO, 32'h0100_0000);
    send_req(CMD_SIN, 32'h0200_0000);
    send_req(CMD_COS, 32'h0080_0000);
    send_req(CMD_TAN, 32'h0080_0000);
    cfg_write(REG_COS_ZERO, 32'h0);
    cfg_write(REG_TERM_STOP, 32'hFFFF_FFFF);
    send_req(CMD_TAN, 32'(PI_HALF_Q24));
    send_req(CMD_SIN, 32'hFF00_0000);
    cfg_write(CFG_IDX_W'($urandom_range(2, 255)), $urandom());
    cfg_write(8'hFF, 32'hFFFF_FFFF);
    send_req(CMD_COS, 32'h0300_0000);
    cfg_write(REG_TERM_STOP, 32'h0);
    cfg_write(REG_COS_ZERO, 32'h1);
    send_req(CMD_TAN, 32'(PI_HALF_Q24 + 3));
    send_req(CMD_TAN, 32'(-PI_HALF_Q24 - 3));
  endtask

  // random requests over several threshold settings
  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin cfg_write(REG_TERM_STOP, 32'd0); cfg_write(REG_COS_ZERO, 32'd1); end
        1: begin cfg_write(REG_TERM_STOP, 32'd16); cfg_write(REG_COS_ZERO, 32'd0); end
        2: begin
          cfg_write(REG_TERM_STOP, $urandom_range(0, 4096));
          cfg_write(REG_COS_ZERO, $urandom_range(0, 1 << 20));
        end
        3: begin cfg_write(REG_TERM_STOP, $urandom()); cfg_write(REG_COS_ZERO, $urandom()); end
        4: cfg_write(REG_COS_ZERO, 32'h0100_0000);
        5: begin cfg_write(REG_TERM_STOP, 32'd1); cfg_write(REG_COS_ZERO, 32'd300); end
        6: begin cfg_write(REG_TERM_STOP, $urandom_range(0, 255)); cfg_write(REG_COS_ZERO, 32'd1); end
        default: no_idle = 1'b1;
      endcase
      for (int k = 0; k < 180; k++) begin
        send_req(2'($urandom_range(0, 3)), rand_angle());
        // sender holds off until the core has caught up
        if (phase == 2 && k == 90) drain();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsc_pkg.sv
hdl/tsc_mul.sv
hdl/tsc_div.sv
hdl/tsc_dp.sv
hdl/tsc_ctrl.sv
hdl/taylor_sine_cosine_tangent_core.sv
tb/tb_taylor_sine_cosine_tangent_core.sv
